FILE: rtl/tfn_pkg.sv
// Package for the triangle face-normal store: command codes, sequencer states
// and the fixed field widths. Used by triangle_face_normal_store.
`default_nettype none
package tfn_pkg;

  localparam int VERTEX_COUNT_DEF = 1024;
  localparam int IDX_W            = 10;
  localparam int COORD_W          = 16;
  localparam int NRM_W            = 16;
  localparam int VEC_W            = 3 * COORD_W;
  localparam int IN_DATA_W        = 80;
  localparam int OUT_DATA_W       = 48;
  localparam logic [16:0] NRM_ONE = 17'd16384;

  typedef enum logic [1:0] {
    CMD_WR_POS = 2'd0,
    CMD_CLR    = 2'd1,
    CMD_TRI    = 2'd2,
    CMD_RD     = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_IDLE,
    ST_RD,
    ST_RDW,
    ST_LDA,
    ST_LDB,
    ST_LDC,
    ST_LDW,
    ST_EDGE,
    ST_XP,
    ST_MAG,
    ST_NORM,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_WRA,
    ST_WRB,
    ST_WRC,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/triangle_face_normal_store.sv
// Triangle face-normal store: position and normal memories with a sequencer that
// forms cross products and normalizes them to Q1.14. Depends on tfn_pkg.
// A triangle runs load and cross-product states, normalizing shifts, 32 square-root
// steps and 3 x 17 divide steps on one multiplier and one divide/root path; a
// degenerate triangle goes from the magnitude state straight to the writes.
// Clear normals sweeps the normal memory, one memory row per cycle.
// After reset the normal memory is swept to zero with in_tready low.
// One item is in work at a time; a result waits in the output register.
`default_nettype none
module triangle_face_normal_store #(
  parameter int VERTEX_COUNT = tfn_pkg::VERTEX_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // vertex_a, vertex_b, vertex_c, pos_x, pos_y, pos_z, two zero bits
  input  wire logic [tfn_pkg::IN_DATA_W-1:0]   in_tdata,
  // command
  input  wire logic [1:0]                      in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // normal_x, normal_y, normal_z
  output logic [tfn_pkg::OUT_DATA_W-1:0]       out_tdata,
  // degenerate
  output logic                                 out_tuser
);
  import tfn_pkg::*;

  localparam int AW = $clog2(VERTEX_COUNT);

  state_t state_r, state_nxt;

  logic [IDX_W-1:0] in_a, in_b, in_c;
  logic             in_xfer;
  assign in_a    = in_tdata[9:0];
  assign in_b    = in_tdata[19:10];
  assign in_c    = in_tdata[29:20];
  assign in_xfer = in_tvalid && in_tready;

  function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
    return (32'(idx) < 32'(VERTEX_COUNT));
  endfunction

  function automatic logic [AW-1:0] idx_addr(input logic [IDX_W-1:0] idx);
    logic [AW+IDX_W-1:0] ext;
    ext = {{AW{1'b0}}, idx};
    return ext[AW-1:0];
  endfunction

  // Item registers
  cmd_t             cmd_r;
  logic [IDX_W-1:0] a_r, b_r, c_r;
  logic [AW-1:0]    swp_r;
  logic [5:0]       step_r;
  logic [1:0]       kdv_r;

  // Memories
  logic [VEC_W-1:0] pos_mem [VERTEX_COUNT];
  logic [VEC_W-1:0] nrm_mem [VERTEX_COUNT];
  logic [VEC_W-1:0] pos_q_r, nrm_q_r;
  logic [AW-1:0]    pos_raddr, nrm_addr;
  logic             pos_we, nrm_we;
  logic [VEC_W-1:0] nrm_wdata;

  assign pos_we = in_xfer && (in_tuser == CMD_WR_POS) && idx_ok(in_a);

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[idx_addr(in_a)] <= in_tdata[77:30];
    end
    pos_q_r <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (nrm_we) begin
      nrm_mem[nrm_addr] <= nrm_wdata;
    end
    nrm_q_r <= nrm_mem[nrm_addr];
  end

  // Datapath registers
  logic signed [16:0] p0_r [3];
  logic signed [16:0] p1_r [3];
  logic signed [16:0] p2_r [3];
  logic signed [16:0] e1_r [3];
  logic signed [16:0] e2_r [3];
  logic signed [34:0] cr_r [3];
  logic        [33:0] m_r [3];
  logic               neg_r [3];
  logic        [33:0] mx_r;
  logic        [33:0] mag_mx;
  logic signed [20:0] mul_a, mul_b;
  logic signed [41:0] prod_r;
  logic        [41:0] s_r;
  logic        [63:0] sq_n_r, sq_res_r, sq_bit_r;
  logic        [31:0] rem_r;
  logic        [16:0] q_r;
  logic signed [15:0] n_r [3];
  logic               deg_r;

  logic               out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic               out_user_r;
  logic               out_load;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_load   = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  function automatic logic signed [16:0] pos_comp(input logic [VEC_W-1:0] v,
                                                  input int k, input logic ok);
    logic [15:0] f;
    f = v[k*COORD_W +: COORD_W];
    return ok ? {f[15], f} : 17'sd0;
  endfunction

  function automatic logic signed [20:0] sx17(input logic signed [16:0] v);
    return {{4{v[16]}}, v};
  endfunction

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:  if (swp_r == AW'(VERTEX_COUNT - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (cmd_t'(in_tuser))
            CMD_WR_POS: state_nxt = ST_IDLE;
            CMD_CLR:    state_nxt = ST_CLR;
            CMD_TRI:    state_nxt = ST_LDA;
            CMD_RD:     state_nxt = ST_RD;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RD:   state_nxt = ST_RDW;
      ST_RDW:  state_nxt = ST_OUT;
      ST_LDA:  state_nxt = ST_LDB;
      ST_LDB:  state_nxt = ST_LDC;
      ST_LDC:  state_nxt = ST_LDW;
      ST_LDW:  state_nxt = ST_EDGE;
      ST_EDGE: state_nxt = ST_XP;
      ST_XP:   if (step_r == 6'd6) state_nxt = ST_MAG;
      ST_MAG: begin
        if (mag_mx == '0) state_nxt = ST_WRA;
        else              state_nxt = ST_NORM;
      end
      ST_NORM: begin
        if ((mx_r[33:20] == '0) && mx_r[19]) state_nxt = ST_SQ;
      end
      ST_SQ:   if (step_r == 6'd3) state_nxt = ST_SQRT;
      ST_SQRT: if (step_r == 6'd31) state_nxt = ST_DIV;
      ST_DIV:  if ((step_r == 6'd16) && (kdv_r == 2'd2)) state_nxt = ST_WRA;
      ST_WRA:  state_nxt = ST_WRB;
      ST_WRB:  state_nxt = ST_WRC;
      ST_WRC:  state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs: handshake, memory ports, multiplier operands
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    pos_raddr = idx_addr(a_r);
    nrm_addr  = idx_addr(a_r);
    nrm_we    = 1'b0;
    nrm_wdata = {n_r[2], n_r[1], n_r[0]};
    mul_a     = sx17(e1_r[1]);
    mul_b     = sx17(e2_r[2]);
    unique case (state_r)
      ST_CLR: begin
        nrm_addr  = swp_r;
        nrm_we    = 1'b1;
        nrm_wdata = '0;
      end
      ST_LDB: pos_raddr = idx_addr(b_r);
      ST_LDC: pos_raddr = idx_addr(c_r);
      ST_WRA: nrm_we = idx_ok(a_r);
      ST_WRB: begin
        nrm_addr = idx_addr(b_r);
        nrm_we   = idx_ok(b_r);
      end
      ST_WRC: begin
        nrm_addr = idx_addr(c_r);
        nrm_we   = idx_ok(c_r);
      end
      default: ;
    endcase
    if (state_r == ST_XP) begin
      unique case (step_r)
        6'd1:    begin mul_a = sx17(e1_r[2]); mul_b = sx17(e2_r[1]); end
        6'd2:    begin mul_a = sx17(e1_r[2]); mul_b = sx17(e2_r[0]); end
        6'd3:    begin mul_a = sx17(e1_r[0]); mul_b = sx17(e2_r[2]); end
        6'd4:    begin mul_a = sx17(e1_r[0]); mul_b = sx17(e2_r[1]); end
        6'd5:    begin mul_a = sx17(e1_r[1]); mul_b = sx17(e2_r[0]); end
        default: ;
      endcase
    end else if (state_r == ST_SQ) begin
      unique case (step_r)
        6'd1:    begin mul_a = {1'b0, m_r[1][19:0]}; mul_b = {1'b0, m_r[1][19:0]}; end
        6'd2:    begin mul_a = {1'b0, m_r[2][19:0]}; mul_b = {1'b0, m_r[2][19:0]}; end
        default: begin mul_a = {1'b0, m_r[0][19:0]}; mul_b = {1'b0, m_r[0][19:0]}; end
      endcase
    end
  end

  // Combinational helpers for the datapath
  logic [33:0] mag [3];
  logic [63:0] sq_t;
  logic        sq_ge;
  logic [32:0] dv_t;
  logic        dv_ge;
  logic [16:0] q_fin, q_half;
  logic [17:0] q_inc;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = cr_r[k][34] ? 34'(-cr_r[k]) : cr_r[k][33:0];
    end
    mag_mx = (mag[0] > mag[1]) ? ((mag[0] > mag[2]) ? mag[0] : mag[2])
                               : ((mag[1] > mag[2]) ? mag[1] : mag[2]);
    sq_t   = sq_res_r + sq_bit_r;
    sq_ge  = (sq_n_r >= sq_t);
    dv_t   = {rem_r, 1'b0};
    dv_ge  = (dv_t >= {1'b0, sq_res_r[31:0]});
    q_fin  = {q_r[15:0], dv_ge};
    q_inc  = 18'(q_fin) + 18'd1;
    q_half = (q_inc[17:1] > NRM_ONE) ? NRM_ONE : q_inc[17:1];
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_r <= cmd_t'(in_tuser);
          a_r   <= in_a;
          b_r   <= in_b;
          c_r   <= in_c;
        end
      end
      ST_RDW: begin
        for (int k = 0; k < 3; k++) begin
          n_r[k] <= idx_ok(a_r) ? nrm_q_r[k*NRM_W +: NRM_W] : 16'sd0;
        end
        deg_r <= 1'b0;
      end
      ST_LDB: for (int k = 0; k < 3; k++) p0_r[k] <= pos_comp(pos_q_r, k, idx_ok(a_r));
      ST_LDC: for (int k = 0; k < 3; k++) p1_r[k] <= pos_comp(pos_q_r, k, idx_ok(b_r));
      ST_LDW: for (int k = 0; k < 3; k++) p2_r[k] <= pos_comp(pos_q_r, k, idx_ok(c_r));
      ST_EDGE: begin
        for (int k = 0; k < 3; k++) begin
          e1_r[k] <= p1_r[k] - p0_r[k];
          e2_r[k] <= p2_r[k] - p0_r[k];
        end
      end
      ST_XP: begin
        // The product of step j lands in prod_r in the next cycle.
        unique case (step_r)
          6'd1:    cr_r[0] <= prod_r[34:0];
          6'd2:    cr_r[0] <= cr_r[0] - prod_r[34:0];
          6'd3:    cr_r[1] <= prod_r[34:0];
          6'd4:    cr_r[1] <= cr_r[1] - prod_r[34:0];
          6'd5:    cr_r[2] <= prod_r[34:0];
          6'd6:    cr_r[2] <= cr_r[2] - prod_r[34:0];
          default: ;
        endcase
      end
      ST_MAG: begin
        for (int k = 0; k < 3; k++) begin
          m_r[k]   <= mag[k];
          neg_r[k] <= cr_r[k][34];
          n_r[k]   <= 16'sd0;
        end
        mx_r  <= mag_mx;
        deg_r <= (cr_r[0] == '0) && (cr_r[1] == '0) && (cr_r[2] == '0);
      end
      ST_NORM: begin
        // All three magnitudes move together, one bit per cycle.
        if (mx_r[33:20] != '0) begin
          mx_r <= mx_r >> 1;
          for (int k = 0; k < 3; k++) m_r[k] <= m_r[k] >> 1;
        end else if (!mx_r[19]) begin
          mx_r <= mx_r << 1;
          for (int k = 0; k < 3; k++) m_r[k] <= m_r[k] << 1;
        end
      end
      ST_SQ: begin
        if (step_r == 6'd1) begin
          s_r <= prod_r[41:0];
        end else if (step_r != 6'd0) begin
          s_r <= s_r + prod_r[41:0];
        end
        if (step_r == 6'd3) begin
          sq_n_r   <= {2'b00, s_r + prod_r[41:0], 20'd0};
          sq_res_r <= '0;
          sq_bit_r <= 64'd1 << 62;
        end
      end
      ST_SQRT: begin
        if (sq_ge) begin
          sq_n_r   <= sq_n_r - sq_t;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
        if (step_r == 6'd31) begin
          rem_r <= {4'd0, m_r[0][19:0], 8'd0};
          q_r   <= '0;
        end
      end
      ST_DIV: begin
        // Restoring division of m << 25 by the root; the low dividend bits are zero.
        if (step_r == 6'd16) begin
          n_r[kdv_r] <= q_half[14] ? (neg_r[kdv_r] ? -16'sd16384 : 16'sd16384)
                                   : (neg_r[kdv_r] ? -$signed({1'b0, q_half[14:0]})
                                                   : $signed({1'b0, q_half[14:0]}));
          rem_r <= {4'd0, m_r[(kdv_r == 2'd0) ? 1 : 2][19:0], 8'd0};
          q_r   <= '0;
        end else begin
          rem_r <= dv_ge ? 32'(dv_t - {1'b0, sq_res_r[31:0]}) : dv_t[31:0];
          q_r   <= q_fin;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      swp_r       <= '0;
      step_r      <= '0;
      kdv_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) begin
        swp_r <= (swp_r == AW'(VERTEX_COUNT - 1)) ? '0 : swp_r + 1'b1;
      end
      if (state_nxt != state_r) begin
        step_r <= '0;
      end else if (state_r == ST_DIV && step_r == 6'd16) begin
        step_r <= '0;
      end else begin
        step_r <= step_r + 1'b1;
      end
      if (state_r == ST_SQRT) begin
        kdv_r <= '0;
      end else if (state_r == ST_DIV && step_r == 6'd16) begin
        kdv_r <= kdv_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {n_r[2], n_r[1], n_r[0]};
      out_user_r <= deg_r && (cmd_r == CMD_TRI);
    end
  end

endmodule
`default_nettype wire
